@@ rtl/core/mtr_pkg.sv @@
// shared types and constants for the mandelbrot tile renderer
package mtr_pkg;

  localparam int unsigned ROW_W   = 6;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned FB_W    = 13;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [COORD_W-1:0] ORIGIN_REAL_RST = 32'hFFFD_8000;
  localparam logic [COORD_W-1:0] ORIGIN_IMAG_RST = 32'h0001_2000;
  localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 31'd2456;

  localparam logic [WORD_W-1:0] TILE_BASE     = 16'h1C00;
  localparam logic [WORD_W-1:0] ESCAPE_OFFSET = 16'd33;
  localparam logic [WORD_W-1:0] BOUNDED_CODE  = 16'd32;

  localparam logic [1:0] REG_ORIGIN_REAL = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IMAG = 2'd1;
  localparam logic [1:0] REG_STEP_SIZE   = 2'd2;

  typedef struct packed {
    logic load;
    logic upd_z;
    logic mul;
    logic inc;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
  } status_t;

endpackage

@@ rtl/core/mtr_tile_if.sv @@
// tile position channel
interface mtr_tile_if;
  logic                         valid;
  logic                         ready;
  logic [mtr_pkg::ROW_W-1:0]    tile_row;
  logic [mtr_pkg::COL_W-1:0]    tile_col;

  modport source (output valid, output tile_row, output tile_col, input ready);
  modport sink (input valid, input tile_row, input tile_col, output ready);
endinterface

@@ rtl/core/mtr_result_if.sv @@
// tile result channel
interface mtr_result_if;
  logic                          valid;
  logic                          ready;
  logic [mtr_pkg::FB_W-1:0]      fb_index;
  logic [mtr_pkg::COUNT_W-1:0]   iter_count;
  logic [mtr_pkg::WORD_W-1:0]    tile_word;

  modport source (output valid, output fb_index, output iter_count, output tile_word,
                  input ready);
  modport sink (input valid, input fb_index, input iter_count, input tile_word,
                output ready);
endinterface

@@ rtl/core/mtr_ctrl.sv @@
// sequencing state machine for the escape-time iteration
module mtr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mtr_pkg::status_t status_i,
  output mtr_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZUPD,
    ST_MUL,
    ST_TEST,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ZUPD;
        end
      end
      ST_ZUPD: begin
        cmd_o.upd_z = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_TEST;
      end
      ST_TEST: begin
        if (status_i.escape || status_i.last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.upd_z = 1'b1;
          cmd_o.inc   = 1'b1;
          state_d     = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.upd_z, cmd_o.mul, cmd_o.finish, cmd_o.emit}))
    else $error("more than one datapath command");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ZUPD && !in_ready_o))
    else $error("tile transfer did not start iteration");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == ST_DONE && !in_ready_o))
    else $error("finish not followed by result hand-off");
`endif

endmodule

@@ rtl/core/mtr_datapath.sv @@
// coordinate, complex square and escape test datapath
module mtr_datapath #(
  parameter int unsigned MAX_ITER  = 56,
  parameter int unsigned COLS      = 80,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtr_pkg::cmd_t                  cmd_i,
  output mtr_pkg::status_t               status_o,
  input  logic [mtr_pkg::COORD_W-1:0]    origin_real_i,
  input  logic [mtr_pkg::COORD_W-1:0]    origin_imag_i,
  input  logic [mtr_pkg::STEP_W-1:0]     step_size_i,
  input  logic [mtr_pkg::ROW_W-1:0]      tile_row_i,
  input  logic [mtr_pkg::COL_W-1:0]      tile_col_i,
  output logic [mtr_pkg::FB_W-1:0]       fb_index_o,
  output logic [mtr_pkg::COUNT_W-1:0]    iter_count_o,
  output logic [mtr_pkg::WORD_W-1:0]     tile_word_o
);

  localparam int unsigned IW    = $clog2(MAX_ITER + 1);
  localparam int unsigned CW    = mtr_pkg::COORD_W;
  localparam int          LIMIT = 4 << FRAC_BITS;

  logic [mtr_pkg::FB_W-1:0] fb_q;
  logic [CW-1:0]            cre_q, cim_q, zre_q, zim_q;
  logic [CW-1:0]            sqre_q, sqim_q, cross_q;
  logic [IW-1:0]            iter_q, cnt_q;
  logic                     esc_q;
  logic [mtr_pkg::FB_W-1:0] fb_out_q;
  logic [IW-1:0]            cnt_out_q;
  logic                     esc_out_q;

  logic [15:0]              fb_full;
  logic [CW-1:0]            step_col, step_row, norm;
  logic signed [63:0]       p_rr, p_ii, p_ri;

  assign fb_full  = 16'(tile_row_i) * 16'(COLS) + 16'(tile_col_i);
  assign step_col = CW'(step_size_i) * CW'(tile_col_i);
  assign step_row = CW'(step_size_i) * CW'(tile_row_i);

  assign p_rr = $signed(zre_q) * $signed(zre_q);
  assign p_ii = $signed(zim_q) * $signed(zim_q);
  assign p_ri = $signed(zre_q) * $signed(zim_q);

  assign norm            = sqre_q + sqim_q;
  assign status_o.escape = $signed(norm) > LIMIT;
  assign status_o.last   = (iter_q == IW'(MAX_ITER - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.load) begin
      iter_q <= '0;
    end else if (cmd_i.inc) begin
      iter_q <= iter_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fb_q    <= fb_full[mtr_pkg::FB_W-1:0];
      cre_q   <= origin_real_i + step_col;
      cim_q   <= origin_imag_i - step_row;
      sqre_q  <= '0;
      sqim_q  <= '0;
      cross_q <= '0;
    end
    if (cmd_i.upd_z) begin
      zre_q <= cre_q + sqre_q - sqim_q;
      zim_q <= cim_q + {cross_q[CW-2:0], 1'b0};
    end
    if (cmd_i.mul) begin
      sqre_q  <= p_rr[FRAC_BITS +: CW];
      sqim_q  <= p_ii[FRAC_BITS +: CW];
      cross_q <= p_ri[FRAC_BITS +: CW];
    end
    if (cmd_i.finish) begin
      esc_q <= status_o.escape;
      cnt_q <= status_o.escape ? iter_q : IW'(MAX_ITER);
    end
    if (cmd_i.emit) begin
      fb_out_q  <= fb_q;
      cnt_out_q <= cnt_q;
      esc_out_q <= esc_q;
    end
  end

  assign fb_index_o   = fb_out_q;
  assign iter_count_o = mtr_pkg::COUNT_W'(cnt_out_q);
  assign tile_word_o  = esc_out_q
                      ? (mtr_pkg::TILE_BASE | (mtr_pkg::ESCAPE_OFFSET + 16'(cnt_out_q)))
                      : (mtr_pkg::TILE_BASE | mtr_pkg::BOUNDED_CODE);

endmodule

@@ rtl/core/mandelbrot_tile_renderer_top.sv @@
// top level of the mandelbrot tile renderer with its register port
//
//   channel    dir  content                                 transfer when
//   tile_i     in   tile_row, tile_col                      valid && ready
//   result_o   out  fb_index, iter_count, tile_word         valid && ready
//   apb        in   origin_real, origin_imag, step_size     psel && penable && pwrite
//
// one tile runs k = count+1 iterations if it escapes, MAX_ITER otherwise
// each iteration goes through the three-multiplier step:
// ST_MUL to multiply, then ST_TEST to add, compare and form the next z
// a new tile is taken only between tiles, a finished result may still wait
// a stalled result holds the last stage, reset clears control state and view registers
module mandelbrot_tile_renderer_top #(
  parameter int unsigned MAX_ITER  = 56,
  parameter int unsigned COLS      = 80,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mtr_tile_if.sink                     tile_i,
  mtr_result_if.source                 result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtr_pkg::PADDR_W-1:0]  paddr,
  input  logic [mtr_pkg::PDATA_W-1:0]  pwdata,
  output logic [mtr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [mtr_pkg::COORD_W-1:0] origin_real_q, origin_imag_q;
  logic [mtr_pkg::STEP_W-1:0]  step_size_q;
  logic [1:0]                  reg_idx;
  logic                        wr_en;
  mtr_pkg::cmd_t               cmd;
  mtr_pkg::status_t            status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q <= mtr_pkg::ORIGIN_REAL_RST;
      origin_imag_q <= mtr_pkg::ORIGIN_IMAG_RST;
      step_size_q   <= mtr_pkg::STEP_SIZE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mtr_pkg::REG_ORIGIN_REAL: origin_real_q <= pwdata;
        mtr_pkg::REG_ORIGIN_IMAG: origin_imag_q <= pwdata;
        mtr_pkg::REG_STEP_SIZE:   step_size_q   <= pwdata[mtr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mtr_pkg::REG_ORIGIN_REAL: prdata = origin_real_q;
      mtr_pkg::REG_ORIGIN_IMAG: prdata = origin_imag_q;
      mtr_pkg::REG_STEP_SIZE:   prdata = {1'b0, step_size_q};
      default:                  prdata = '0;
    endcase
  end

  mtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tile_i.valid),
    .in_ready_o  (tile_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtr_datapath #(
    .MAX_ITER  (MAX_ITER),
    .COLS      (COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .origin_real_i (origin_real_q),
    .origin_imag_i (origin_imag_q),
    .step_size_i   (step_size_q),
    .tile_row_i    (tile_i.tile_row),
    .tile_col_i    (tile_i.tile_col),
    .fb_index_o    (result_o.fb_index),
    .iter_count_o  (result_o.iter_count),
    .tile_word_o   (result_o.tile_word)
  );

endmodule

@@ bench/mtr_tile_checker.sv @@
// checker that predicts and compares every tile result of the renderer
`timescale 1ns / 100ps

module mtr_tile_checker #(
  parameter int unsigned MAX_ITER  = 56,
  parameter int unsigned COLS      = 80,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mtr_tile_if                          tile_i,
  mtr_result_if                        result_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [mtr_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [mtr_pkg::PDATA_W-1:0]  pwdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o,
  output int unsigned                  bounded_o
);

  typedef struct packed {
    logic [mtr_pkg::FB_W-1:0]    fb_index;
    logic [mtr_pkg::COUNT_W-1:0] iter_count;
    logic [mtr_pkg::WORD_W-1:0]  tile_word;
  } tile_result_t;

  typedef logic [mtr_pkg::COORD_W-1:0] coord_t;

  localparam logic signed [mtr_pkg::COORD_W-1:0] ESCAPE_LIMIT = 32'sd4 << FRAC_BITS;

  coord_t                          origin_real;
  coord_t                          origin_imag;
  logic [mtr_pkg::STEP_W-1:0]      step_size;
  tile_result_t                    expected_tiles[$];
  int unsigned                     fail_count = 0;
  int unsigned                     checked = 0;
  int unsigned                     bounded = 0;

  function automatic coord_t q_mul(coord_t a, coord_t b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return mtr_pkg::COORD_W'(p >>> FRAC_BITS);
  endfunction

  function automatic tile_result_t predict_tile(logic [mtr_pkg::ROW_W-1:0] row,
                                                logic [mtr_pkg::COL_W-1:0] col);
    coord_t       cre, cim, zre, zim, sre, sim, norm;
    int unsigned  count;
    tile_result_t r;
    cre = origin_real + {1'b0, step_size} * {25'd0, col};
    cim = origin_imag - {1'b0, step_size} * {26'd0, row};
    zre = '0;
    zim = '0;
    count = MAX_ITER;
    for (int i = 0; i < MAX_ITER; i++) begin
      sre = q_mul(zre, zre) - q_mul(zim, zim);
      sim = q_mul(zre, zim) + q_mul(zim, zre);
      zre = cre + sre;
      zim = cim + sim;
      norm = q_mul(zre, zre) + q_mul(zim, zim);
      if ($signed(norm) > ESCAPE_LIMIT) begin
        count = i;
        break;
      end
    end
    r.fb_index   = mtr_pkg::FB_W'(32'(row) * COLS + 32'(col));
    r.iter_count = mtr_pkg::COUNT_W'(count);
    if (count < MAX_ITER) begin
      r.tile_word = mtr_pkg::TILE_BASE |
                    (mtr_pkg::ESCAPE_OFFSET + mtr_pkg::WORD_W'(count));
    end else begin
      r.tile_word = mtr_pkg::TILE_BASE | mtr_pkg::BOUNDED_CODE;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tile_result_t want;
    if (!rst_ni) begin
      origin_real = mtr_pkg::ORIGIN_REAL_RST;
      origin_imag = mtr_pkg::ORIGIN_IMAG_RST;
      step_size   = mtr_pkg::STEP_SIZE_RST;
      expected_tiles.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[mtr_pkg::PADDR_W-1:2])
          mtr_pkg::REG_ORIGIN_REAL: origin_real = pwdata_i;
          mtr_pkg::REG_ORIGIN_IMAG: origin_imag = pwdata_i;
          mtr_pkg::REG_STEP_SIZE:   step_size   = pwdata_i[mtr_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (tile_i.valid && tile_i.ready) begin
        expected_tiles.push_back(predict_tile(tile_i.tile_row, tile_i.tile_col));
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_tiles.size() == 0) begin
          $error("result transfer with no tile outstanding: fb_index %0d", result_i.fb_index);
          fail_count++;
        end else begin
          want = expected_tiles.pop_front();
          checked++;
          if (want.tile_word == (mtr_pkg::TILE_BASE | mtr_pkg::BOUNDED_CODE)) bounded++;
          if (result_i.fb_index !== want.fb_index) begin
            $error("fb_index: expected %0d, actual %0d", want.fb_index, result_i.fb_index);
            fail_count++;
          end
          if (result_i.iter_count !== want.iter_count) begin
            $error("iter_count: expected %0d, actual %0d", want.iter_count,
                   result_i.iter_count);
            fail_count++;
          end
          if (result_i.tile_word !== want.tile_word) begin
            $error("tile_word: expected 0x%04h, actual 0x%04h", want.tile_word,
                   result_i.tile_word);
            fail_count++;
          end
        end
      end
      pending_o <= expected_tiles.size();
    end
  end

  assign fail_count_o = fail_count;
  assign checked_o    = checked;
  assign bounded_o    = bounded;

endmodule

@@ bench/tb.sv @@
// testbench top: stimulus, register setup and verdict for the tile renderer
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAX_ITER    = 56;
  localparam int unsigned COLS        = 80;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned SETTLE      = 150;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mtr_pkg::PADDR_W-1:0]  paddr;
  logic [mtr_pkg::PDATA_W-1:0]  pwdata;
  logic [mtr_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned bounded;
  int unsigned idle_cycles = 0;
  int unsigned reg_writes;
  int unsigned hold_asks = 0;
  bit          idle_on;

  mtr_tile_if   tile_if ();
  mtr_result_if result_if ();

  mandelbrot_tile_renderer_top #(
    .MAX_ITER (MAX_ITER),
    .COLS     (COLS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tile_i  (tile_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mtr_tile_checker #(
    .MAX_ITER (MAX_ITER),
    .COLS     (COLS),
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tile_i      (tile_if),
    .result_i    (result_if),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .bounded_o   (bounded)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((tile_if.valid && tile_if.ready) || (result_if.valid && result_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL mandelbrot_tile_renderer_top");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [mtr_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic send_tile(input logic [mtr_pkg::ROW_W-1:0] row,
                           input logic [mtr_pkg::COL_W-1:0] col);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      tile_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tile_if.valid    <= 1'b1;
    tile_if.tile_row <= row;
    tile_if.tile_col <= col;
    do @(posedge clk_i); while (tile_if.ready !== 1'b1);
  endtask

  // mostly on-screen tiles, some anywhere in the field range
  task automatic send_random_tiles(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_tile(mtr_pkg::ROW_W'($urandom), mtr_pkg::COL_W'($urandom));
      end else begin
        send_tile(mtr_pkg::ROW_W'($urandom_range(0, 59)),
                  mtr_pkg::COL_W'($urandom_range(0, 79)));
      end
    end
  endtask

  task automatic drain;
    tile_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_view(input logic [mtr_pkg::PDATA_W-1:0] re,
                          input logic [mtr_pkg::PDATA_W-1:0] im,
                          input logic [mtr_pkg::PDATA_W-1:0] step);
    write_reg(mtr_pkg::REG_ORIGIN_REAL, re);
    write_reg(mtr_pkg::REG_ORIGIN_IMAG, im);
    write_reg(mtr_pkg::REG_STEP_SIZE, step);
  endtask

  // result side: random stall per transfer, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned holds_done;
    holds_done = 0;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (hold_asks != holds_done) begin
        holds_done++;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (result_if.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    logic [mtr_pkg::ROW_W-1:0] dir_rows[19];
    logic [mtr_pkg::COL_W-1:0] dir_cols[19];
    dir_rows = '{0, 59, 0, 59, 30, 30, 31, 63, 63, 0, 60, 32, 1, 62, 15, 45, 29, 42, 21};
    dir_cols = '{0, 79, 79, 0, 67, 60, 66, 127, 0, 127, 80, 64, 1, 126, 40, 40, 50, 85, 42};
    reg_writes  = 0;
    idle_on     = 1'b1;
    tile_if.valid    <= 1'b0;
    tile_if.tile_row <= '0;
    tile_if.tile_col <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // reset view: corners, off-screen positions, bounded center, instant escape
    for (int k = 0; k < 19; k++) send_tile(dir_rows[k], dir_cols[k]);
    send_random_tiles(150);
    idle_on = 1'b0;
    send_random_tiles(120);
    idle_on = 1'b1;
    drain();

    // extreme registers, coordinates wrap
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_tile(0, 0);
    send_tile(63, 127);
    send_random_tiles(40);
    drain();
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_random_tiles(20);
    drain();

    // c at the origin for every tile, never escapes
    set_view(32'h0, 32'h0, 32'h0);
    send_tile(0, 0);
    send_tile(63, 127);
    send_random_tiles(18);
    drain();

    // zoom near the set boundary for deep iteration counts
    for (int v = 0; v < 5; v++) begin
      set_view(32'(-49807 + $urandom_range(0, 4000) - 2000),
               32'(7864 + $urandom_range(0, 4000) - 2000),
               32'($urandom_range(1, 60)));
      idle_on = (v != 2);
      send_random_tiles(50);
      drain();
    end
    idle_on = 1'b1;

    // arbitrary register values
    for (int v = 0; v < 4; v++) begin
      set_view($urandom, $urandom, ($urandom_range(0, 1) == 1) ? $urandom :
               32'($urandom_range(0, 8000)));
      send_random_tiles(25);
      drain();
    end

    // back to reset view with the result side held off
    set_view(32'hFFFD_8000, 32'h0001_2000, 32'd2456);
    hold_asks++;
    send_random_tiles(75);
    hold_asks++;
    send_random_tiles(75);
    drain();

    repeat (SETTLE) @(posedge clk_i);
    $display("checked %0d tile results, %0d of them bounded, over %0d register writes",
             checked, bounded, reg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS mandelbrot_tile_renderer_top");
    end else begin
      $display("FAIL mandelbrot_tile_renderer_top");
    end
    $finish;
  end

endmodule
